[design/assert_macros.svh]
// Assertion macros shared by the rotary encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[design/rotenc_pkg.sv]
// Types, register codes and reset values for the rotary encoder block.
package rotenc_pkg;

   localparam int CountWidth = 16;
   localparam int TimeWidth  = 32;
   localparam int LoadWidth  = 8;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 16;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_MIN_COUNT     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_COUNT     = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DEBOUNCE_MS   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_COUNT_ENABLE  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_BUTTON_ENABLE = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_INITIAL_COUNT = 3'd5;

   // Reset values
   localparam logic signed [CountWidth-1:0] MIN_COUNT_RST     = 16'sd0;
   localparam logic signed [CountWidth-1:0] MAX_COUNT_RST     = 16'sd100;
   localparam logic [CsrDataW-1:0]          DEBOUNCE_MS_RST   = 16'd50;
   localparam logic                         COUNT_ENABLE_RST  = 1'b1;
   localparam logic                         BUTTON_ENABLE_RST = 1'b1;
   localparam logic signed [CountWidth-1:0] INITIAL_COUNT_RST = 16'sd0;

   // Item commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef struct packed {
      logic                  command;
      logic                  clock_level;
      logic                  direction_level;
      logic                  button_level;
      logic [TimeWidth-1:0]  now_ms;
      logic [LoadWidth-1:0]  load_value;
   } req_type;

   typedef struct packed {
      logic                         turn_right;
      logic                         turn_left;
      logic                         button_press;
      logic signed [CountWidth-1:0] position;
      logic                         last_direction;
   } rsp_type;

   // Configuration seen by the decode core
   typedef struct packed {
      logic signed [CountWidth-1:0] min_count;
      logic signed [CountWidth-1:0] max_count;
      logic [CsrDataW-1:0]          debounce_ms;
      logic                         count_enable;
      logic                         button_enable;
      logic                         pos_load;
      logic signed [CountWidth-1:0] pos_load_value;
   } cfg_type;

endpackage

[design/rotary_encoder_with_button.sv]
// Rotary encoder decoder with push button debounce: top level and pipeline.
// One transaction is taken every clock cycle while req_stall is low. Each result passes
// through the input register and then the result register before rsp_valid rises. rsp_stall
// holds the result register while the input register still takes one more item.
// Every transaction gives exactly one result. A load command sets the position to
// load_value; a sample detects clock-pin rising edges as detents and debounces the
// button on the supplied millisecond timestamps. Writing initial_count also sets
// the position. csr_ready is always high; configure only while the block is idle.
`include "assert_macros.svh"

module rotary_encoder_with_button (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rotenc_pkg::req_type             req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rotenc_pkg::rsp_type             rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rotenc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rotenc_pkg::CsrDataW-1:0] csr_data
);
   import rotenc_pkg::*;

   cfg_type cfg;
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    out_free;
   logic    fire;

   rotenc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rotenc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (s1_data_ff),
      .result (result)
   );

   // Handshake control
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      fire         = s1_valid_ff && out_free;
      req_stall    = s1_valid_ff && !out_free;
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEVER(a_turn_excl, clock, reset, rsp_valid && rsp_data.turn_right && rsp_data.turn_left, "left and right detent in one result")
   `ASSERT_PROP(a_no_drop, clock, reset, s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff, "transaction lost between input and result register")

endmodule

[design/rotenc_csr.sv]
// Configuration registers of the rotary encoder block.
module rotenc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rotenc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rotenc_pkg::CsrDataW-1:0] csr_data,
   output rotenc_pkg::cfg_type             cfg
);
   import rotenc_pkg::*;

   logic signed [CountWidth-1:0] min_count_ff;
   logic signed [CountWidth-1:0] max_count_ff;
   logic [CsrDataW-1:0]          debounce_ff;
   logic                         count_en_ff;
   logic                         button_en_ff;
   logic                         wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   // Register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         min_count_ff <= MIN_COUNT_RST;
         max_count_ff <= MAX_COUNT_RST;
         debounce_ff  <= DEBOUNCE_MS_RST;
         count_en_ff  <= COUNT_ENABLE_RST;
         button_en_ff <= BUTTON_ENABLE_RST;
      end else if (wr) begin
         case (csr_index)
            CSR_MIN_COUNT:     min_count_ff <= csr_data;
            CSR_MAX_COUNT:     max_count_ff <= csr_data;
            CSR_DEBOUNCE_MS:   debounce_ff  <= csr_data;
            CSR_COUNT_ENABLE:  count_en_ff  <= csr_data[0];
            CSR_BUTTON_ENABLE: button_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Initial count write loads the position counter at once
   always_comb begin
      cfg.min_count      = min_count_ff;
      cfg.max_count      = max_count_ff;
      cfg.debounce_ms    = debounce_ff;
      cfg.count_enable   = count_en_ff;
      cfg.button_enable  = button_en_ff;
      cfg.pos_load       = wr && (csr_index == CSR_INITIAL_COUNT);
      cfg.pos_load_value = csr_data;
   end

endmodule

[design/rotenc_core.sv]
// Decode core: encoder edge detect, position counter and button debounce.
`include "assert_macros.svh"

module rotenc_core (
   input  logic                clock,
   input  logic                reset,
   input  rotenc_pkg::cfg_type cfg,
   input  logic                fire,
   input  rotenc_pkg::req_type item,
   output rotenc_pkg::rsp_type result
);
   import rotenc_pkg::*;

   logic                         prev_clk_ff, prev_clk_in;
   logic                         prev_btn_ff, prev_btn_in;
   logic                         press_reported_ff, press_reported_in;
   logic [TimeWidth-1:0]         change_time_ff, change_time_in;
   logic signed [CountWidth-1:0] pos_ff, pos_in;
   logic                         dir_flag_ff, dir_flag_in;

   logic                         btn_changed;
   logic                         rise;
   logic                         right;
   logic                         left;
   logic                         press;
   logic [TimeWidth-1:0]         elapsed;

   // Next state and result for the transaction at hand
   always_comb begin
      prev_clk_in       = prev_clk_ff;
      prev_btn_in       = prev_btn_ff;
      press_reported_in = press_reported_ff;
      change_time_in    = change_time_ff;
      pos_in            = pos_ff;
      dir_flag_in       = dir_flag_ff;
      right             = 1'b0;
      left              = 1'b0;
      press             = 1'b0;
      btn_changed       = item.button_level != prev_btn_ff;
      rise              = item.clock_level && !prev_clk_ff;
      elapsed           = '0;

      if (item.command == CMD_LOAD) begin
         pos_in = {{(CountWidth-LoadWidth){1'b0}}, item.load_value};
      end else begin
         // button debounce, ahead of rotation
         if (btn_changed) begin
            change_time_in    = item.now_ms;
            press_reported_in = 1'b0;
         end
         elapsed = item.now_ms - change_time_in;
         press   = cfg.button_enable && item.button_level && !press_reported_in
                   && (elapsed > {{(TimeWidth-CsrDataW){1'b0}}, cfg.debounce_ms});
         if (press) begin
            press_reported_in = 1'b1;
         end
         prev_btn_in = item.button_level;

         // rotation: detent on rising clock pin
         right = rise && !item.direction_level;
         left  = rise && item.direction_level;
         if (rise) begin
            dir_flag_in = !item.direction_level;
         end
         if (right && cfg.count_enable && (pos_ff < cfg.max_count)) begin
            pos_in = pos_ff + 16'sd1;
         end else if (left && cfg.count_enable && (pos_ff > cfg.min_count)) begin
            pos_in = pos_ff - 16'sd1;
         end
         prev_clk_in = item.clock_level;
      end

      result.turn_right     = right;
      result.turn_left      = left;
      result.button_press   = press;
      result.position       = pos_in;
      result.last_direction = dir_flag_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_clk_ff       <= 1'b0;
         prev_btn_ff       <= 1'b0;
         press_reported_ff <= 1'b0;
         change_time_ff    <= '0;
         pos_ff            <= INITIAL_COUNT_RST;
         dir_flag_ff       <= 1'b0;
      end else if (cfg.pos_load) begin
         pos_ff <= cfg.pos_load_value;
      end else if (fire) begin
         prev_clk_ff       <= prev_clk_in;
         prev_btn_ff       <= prev_btn_in;
         press_reported_ff <= press_reported_in;
         change_time_ff    <= change_time_in;
         pos_ff            <= pos_in;
         dir_flag_ff       <= dir_flag_in;
      end
   end

   `ASSERT_PROP(a_count_frozen, clock, reset, fire && (item.command == CMD_SAMPLE) && !cfg.count_enable && !cfg.pos_load |=> pos_ff == $past(pos_ff), "position moved while counting disabled")
   `ASSERT_PROP(a_one_shot_armed, clock, reset, fire && !cfg.pos_load && result.button_press |=> press_reported_ff, "press reported without arming one-shot")

endmodule
